// ===== hw/rtl/fxva_pkg.sv =====
package fxva_pkg;

  localparam int unsigned COMP_W  = 16;  // input component width
  localparam int unsigned MAG_W   = 17;  // magnitude of a 16-bit two's complement value
  localparam int unsigned NUM_W   = 24;  // small * 450 < 2^24
  localparam int unsigned QUO_W   = 9;   // quotient 0..450
  localparam int unsigned SCALE_W = 9;
  localparam int unsigned CORR_W  = 6;   // correction 0..40
  localparam int unsigned RAT_W   = 10;  // corrected ratio
  localparam int unsigned ANG_W   = 12;

  localparam logic [SCALE_W-1:0] RATIO_SCALE = 9'd450;

  localparam logic [QUO_W-1:0] CORR_SPLIT = 9'd220;
  localparam logic [QUO_W-1:0] HI_T0      = 9'd440;
  localparam logic [QUO_W-1:0] HI_T1      = 9'd410;
  localparam logic [QUO_W-1:0] HI_T2      = 9'd370;
  localparam logic [QUO_W-1:0] HI_T3      = 9'd320;
  localparam logic [QUO_W-1:0] LO_T0      = 9'd20;
  localparam logic [QUO_W-1:0] LO_T1      = 9'd60;
  localparam logic [QUO_W-1:0] LO_T2      = 9'd100;
  localparam logic [QUO_W-1:0] LO_T3      = 9'd150;
  localparam logic [CORR_W-1:0] CORR_STEP = 6'd10;

  localparam logic [RAT_W-1:0] ANG_90  = 10'd900;
  localparam logic [ANG_W-1:0] ANG_180 = 12'd1800;
  localparam logic [ANG_W-1:0] ANG_360 = 12'd3600;

  typedef struct packed {
    logic signed [COMP_W-1:0] x_value;
    logic signed [COMP_W-1:0] y_value;
  } in_t;

  typedef struct packed {
    logic [ANG_W-1:0] angle_tenths;
    logic             zero_vector;
  } out_t;

  // octant / quadrant info riding along the divider
  typedef struct packed {
    logic xneg;
    logic yneg;
    logic swap;
    logic zero;
  } side_t;

  // stepwise correction from threshold compares
  function automatic logic [CORR_W-1:0] correction(input logic [QUO_W-1:0] q);
    logic [CORR_W-1:0] c;
    c = '0;
    if (q > CORR_SPLIT) begin
      if (q <= HI_T0) c = c + CORR_STEP;
      if (q <= HI_T1) c = c + CORR_STEP;
      if (q <= HI_T2) c = c + CORR_STEP;
      if (q <= HI_T3) c = c + CORR_STEP;
    end else begin
      if (q >= LO_T0) c = c + CORR_STEP;
      if (q >= LO_T1) c = c + CORR_STEP;
      if (q >= LO_T2) c = c + CORR_STEP;
      if (q >= LO_T3) c = c + CORR_STEP;
    end
    return c;
  endfunction

endpackage

// ===== hw/rtl/fast_xy_vector_angle.sv =====
// Fast vector angle: signed X/Y in, angle in tenths of a degree out.
//
// Input channel (in_valid / in_stall / in_data): one transfer carries a
// signed 16-bit X and Y. Output channel (out_valid / out_stall / out_data):
// one transfer per input, carrying angle_tenths (0..3600, measured from +Y
// toward +X) and zero_vector, set with angle 0 when both components are 0.
//
// The pipeline has 12 register stages: magnitude, multiply-by-450, nine
// restoring-divider stages (one quotient bit each), then correction/octant-mirror
// into the output register. Throughput is one transfer per cycle while
// out_stall is low.
//
// Each stage holds its own valid bit and advances when it is empty or the
// stage after it advances, so bubbles squeeze out under stall. When the
// receiver stalls, results pile up stage by stage; in_stall rises only once
// every stage is full. Nothing is dropped or repeated.
//
// Reset (rst_n low, synchronous) clears every valid bit and so empties the pipeline; data registers are not reset.
module fast_xy_vector_angle (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_stall,
  input  fxva_pkg::in_t   in_data,
  output logic            out_valid,
  input  logic            out_stall,
  output fxva_pkg::out_t  out_data
);

  localparam int unsigned MAG_W = fxva_pkg::MAG_W;
  localparam int unsigned PRD_W = MAG_W + fxva_pkg::SCALE_W;

  // ---- stage 1: magnitudes, swap and sign flags
  logic             s1_valid_r;
  logic [MAG_W-1:0] s1_small_r;
  logic [MAG_W-1:0] s1_big_r;
  fxva_pkg::side_t  s1_side_r;
  logic             s1_rdy;

  // ---- stage 2: small * 450
  logic                         s2_valid_r;
  logic [fxva_pkg::NUM_W-1:0]   s2_num_r;
  logic [MAG_W-1:0]             s2_den_r;
  fxva_pkg::side_t              s2_side_r;
  logic                         s2_rdy;

  // ---- divider
  logic                         div_in_rdy;
  logic                         div_valid;
  logic                         div_rdy;
  logic [fxva_pkg::QUO_W-1:0]   div_quo;
  fxva_pkg::side_t              div_side;

  // ---- output register
  logic                         out_valid_r;
  fxva_pkg::out_t               out_data_r;

  logic [MAG_W-1:0] ax;
  logic [MAG_W-1:0] ay;
  logic [MAG_W-1:0] x_ext;
  logic [MAG_W-1:0] y_ext;
  fxva_pkg::side_t  side_nxt;
  logic [PRD_W-1:0] prod;

  logic [fxva_pkg::RAT_W-1:0] ratio;
  logic [fxva_pkg::ANG_W-1:0] r_ext;
  fxva_pkg::out_t             out_nxt;

  // ready chain, back to front
  assign div_rdy  = !out_valid_r || !out_stall;
  assign s2_rdy   = !s2_valid_r || div_in_rdy;
  assign s1_rdy   = !s1_valid_r || s2_rdy;
  assign in_stall = !s1_rdy;

  // sign-extend, then negate; -32768 gives 32768 in 17 bits
  always_comb begin
    x_ext = {in_data.x_value[fxva_pkg::COMP_W-1], in_data.x_value};
    y_ext = {in_data.y_value[fxva_pkg::COMP_W-1], in_data.y_value};
    ax    = in_data.x_value[fxva_pkg::COMP_W-1] ? MAG_W'(0 - x_ext) : x_ext;
    ay    = in_data.y_value[fxva_pkg::COMP_W-1] ? MAG_W'(0 - y_ext) : y_ext;
    side_nxt.xneg = in_data.x_value[fxva_pkg::COMP_W-1];
    side_nxt.yneg = in_data.y_value[fxva_pkg::COMP_W-1];
    side_nxt.swap = ax > ay;
    side_nxt.zero = (ax == '0) && (ay == '0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (s1_rdy) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_rdy && in_valid) begin
      s1_small_r <= side_nxt.swap ? ay : ax;
      s1_big_r   <= side_nxt.swap ? ax : ay;
      s1_side_r  <= side_nxt;
    end
  end

  // small <= big, so the quotient stays within 0..450
  assign prod = PRD_W'(s1_small_r) * PRD_W'(fxva_pkg::RATIO_SCALE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r <= 1'b0;
    end else if (s2_rdy) begin
      s2_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_rdy && s1_valid_r) begin
      s2_num_r  <= prod[fxva_pkg::NUM_W-1:0];
      s2_den_r  <= s1_big_r;
      s2_side_r <= s1_side_r;
    end
  end

  // zero divisor gives a junk quotient; the zero flag masks it below
  fxva_div_pipe u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (s2_valid_r),
    .in_rdy    (div_in_rdy),
    .in_num    (s2_num_r),
    .in_den    (s2_den_r),
    .in_side   (s2_side_r),
    .out_valid (div_valid),
    .out_rdy   (div_rdy),
    .out_quo   (div_quo),
    .out_side  (div_side)
  );

  // correction, octant swap, quadrant mirror
  always_comb begin
    ratio = fxva_pkg::RAT_W'(div_quo) + fxva_pkg::RAT_W'(fxva_pkg::correction(div_quo));
    if (div_side.swap) begin
      ratio = fxva_pkg::ANG_90 - ratio;
    end
    r_ext = fxva_pkg::ANG_W'(ratio);
    case ({div_side.yneg, div_side.xneg})
      2'b00:   out_nxt.angle_tenths = r_ext;
      2'b01:   out_nxt.angle_tenths = fxva_pkg::ANG_360 - r_ext;
      2'b10:   out_nxt.angle_tenths = fxva_pkg::ANG_180 - r_ext;
      2'b11:   out_nxt.angle_tenths = fxva_pkg::ANG_180 + r_ext;
      default: out_nxt.angle_tenths = r_ext;
    endcase
    out_nxt.zero_vector = div_side.zero;
    if (div_side.zero) begin
      out_nxt.angle_tenths = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (div_rdy) begin
      out_valid_r <= div_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (div_rdy && div_valid) begin
      out_data_r <= out_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// ===== hw/rtl/fxva_div_pipe.sv =====
// Restoring divider, one quotient bit per stage. Dividend must be below
// 2^QUO_W times the divisor.
module fxva_div_pipe (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_rdy,
  input  logic [fxva_pkg::NUM_W-1:0]   in_num,
  input  logic [fxva_pkg::MAG_W-1:0]   in_den,
  input  fxva_pkg::side_t              in_side,
  output logic                         out_valid,
  input  logic                         out_rdy,
  output logic [fxva_pkg::QUO_W-1:0]   out_quo,
  output fxva_pkg::side_t              out_side
);

  localparam int unsigned STEPS = fxva_pkg::QUO_W;
  localparam int unsigned MAG_W = fxva_pkg::MAG_W;
  localparam int unsigned HI_W  = fxva_pkg::NUM_W - STEPS;

  logic                 valid_r [STEPS];
  logic [MAG_W-1:0]     rem_r   [STEPS];
  logic [STEPS-1:0]     low_r   [STEPS];
  logic [STEPS-1:0]     quo_r   [STEPS];
  logic [MAG_W-1:0]     den_r   [STEPS];
  fxva_pkg::side_t      side_r  [STEPS];
  logic                 rdy     [STEPS+1];

  assign rdy[STEPS] = out_rdy;
  assign in_rdy     = rdy[0];

  for (genvar i = 0; i < STEPS; i++) begin : g_step
    logic             src_valid;
    logic [MAG_W-1:0] src_rem;
    logic [STEPS-1:0] src_low;
    logic [STEPS-1:0] src_quo;
    logic [MAG_W-1:0] src_den;
    fxva_pkg::side_t  src_side;
    logic [MAG_W:0]   trial;
    logic             ge;
    logic [MAG_W-1:0] rem_nxt;

    if (i == 0) begin : g_src_in
      assign src_valid = in_valid;
      assign src_rem   = MAG_W'(in_num[fxva_pkg::NUM_W-1 -: HI_W]);
      assign src_low   = in_num[STEPS-1:0];
      assign src_quo   = '0;
      assign src_den   = in_den;
      assign src_side  = in_side;
    end else begin : g_src_prev
      assign src_valid = valid_r[i-1];
      assign src_rem   = rem_r[i-1];
      assign src_low   = low_r[i-1];
      assign src_quo   = quo_r[i-1];
      assign src_den   = den_r[i-1];
      assign src_side  = side_r[i-1];
    end

    assign rdy[i] = !valid_r[i] || rdy[i+1];

    always_comb begin
      trial   = {src_rem, src_low[STEPS-1]};
      ge      = trial >= {1'b0, src_den};
      rem_nxt = ge ? MAG_W'(trial - {1'b0, src_den}) : trial[MAG_W-1:0];
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        valid_r[i] <= 1'b0;
      end else if (rdy[i]) begin
        valid_r[i] <= src_valid;
      end
    end

    always_ff @(posedge clk) begin
      if (rdy[i] && src_valid) begin
        rem_r[i]  <= rem_nxt;
        low_r[i]  <= {src_low[STEPS-2:0], 1'b0};
        quo_r[i]  <= {src_quo[STEPS-2:0], ge};
        den_r[i]  <= src_den;
        side_r[i] <= src_side;
      end
    end
  end

  assign out_valid = valid_r[STEPS-1];
  assign out_quo   = quo_r[STEPS-1];
  assign out_side  = side_r[STEPS-1];

endmodule
